// ----- hw/rtl/srlr_pkg.sv -----
// ----------------------------------------------------------------------------
// Stereo ring resampler package
// Shared widths, reset values, register codes and pipeline control types.
// ----------------------------------------------------------------------------
package srlr_pkg;

    // Sample and field widths.
    localparam int DATA_W     = 16;
    localparam int STEP_W     = 24;
    localparam int SUM_W      = STEP_W + 1;
    localparam int BUF_W      = 11;
    localparam int CFG_DATA_W = 24;
    localparam int CFG_IDX_W  = 1;

    // Parameter defaults for the top level.
    localparam int RING_AW_DEF   = 10;
    localparam int FRAC_BITS_DEF = 16;

    // Register reset values.
    localparam logic [STEP_W-1:0] PHASE_STEP_RST = 24'h010000;
    localparam logic              INTERP_ON_RST  = 1'b1;

    // Request codes carried in req_type.
    localparam logic REQ_PUSH = 1'b0;
    localparam logic REQ_PULL = 1'b1;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PHASE_STEP = 1'b0,
        REG_INTERP_ON  = 1'b1
    } cfg_reg_t;

    // Stage enables handed to each channel lane.
    typedef struct packed {
        logic en_b;
        logic en_c;
    } lane_ctrl_t;

endpackage

// ----- hw/rtl/srlr_if.sv -----
// ----------------------------------------------------------------------------
// Stereo ring resampler channels
// Valid/ready channel interfaces for request words and output frame words.
// ----------------------------------------------------------------------------
interface srlr_in_if;
    logic                                valid;
    logic                                ready;
    logic                                req_type;
    logic signed [srlr_pkg::DATA_W-1:0]  in_left;
    logic signed [srlr_pkg::DATA_W-1:0]  in_right;

    modport source (output valid, output req_type, output in_left, output in_right,
                    input ready);
    modport sink   (input valid, input req_type, input in_left, input in_right,
                    output ready);
endinterface

interface srlr_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [srlr_pkg::DATA_W-1:0]  out_left;
    logic signed [srlr_pkg::DATA_W-1:0]  out_right;
    logic        [srlr_pkg::BUF_W-1:0]   frames_buffered;

    modport source (output valid, output out_left, output out_right,
                    output frames_buffered, input ready);
    modport sink   (input valid, input out_left, input out_right,
                    input frames_buffered, output ready);
endinterface

// ----- hw/rtl/srlr_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and two read ports with registered, enabled read data.
// ----------------------------------------------------------------------------
module srlr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read ports, held while the reader stalls.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

// ----- hw/rtl/srlr_lane.sv -----
// ----------------------------------------------------------------------------
// Resampler channel lane
// Forms the difference of two neighboring samples and scales it by the phase.
// ----------------------------------------------------------------------------
module srlr_lane #(
    parameter int FRAC_BITS = srlr_pkg::FRAC_BITS_DEF
) (
    input  logic                                     clk,
    input  srlr_pkg::lane_ctrl_t                     ctl,
    input  logic signed [srlr_pkg::DATA_W-1:0]       first,
    input  logic signed [srlr_pkg::DATA_W-1:0]       second,
    input  logic        [FRAC_BITS-1:0]              frac,
    output logic                                     prod_neg,
    output logic signed [srlr_pkg::DATA_W-1:0]       prod_base,
    output logic        [srlr_pkg::DATA_W+FRAC_BITS-1:0] prod_mag
);

    localparam int DW = srlr_pkg::DATA_W;
    localparam int PW = DW + FRAC_BITS;

    logic signed [DW:0]   diff;
    logic        [DW:0]   diff_abs;

    logic                 neg_b_reg;
    logic signed [DW-1:0] base_b_reg;
    logic [DW-1:0]        mag_b_reg;
    logic [FRAC_BITS-1:0] frac_b_reg;

    logic                 neg_c_reg;
    logic signed [DW-1:0] base_c_reg;
    logic [PW-1:0]        prod_c_reg;

    // Signed difference and its magnitude, which always fits the sample width.
    assign diff     = {second[DW-1], second} - {first[DW-1], first};
    assign diff_abs = diff[DW] ? (~diff + 1'b1) : diff;

    // Difference stage.
    always_ff @(posedge clk)
    begin
        if (ctl.en_b)
        begin
            neg_b_reg  <= diff[DW];
            base_b_reg <= first;
            mag_b_reg  <= diff_abs[DW-1:0];
            frac_b_reg <= frac;
        end
    end

    // Multiply stage: magnitude times the fraction.
    always_ff @(posedge clk)
    begin
        if (ctl.en_c)
        begin
            neg_c_reg  <= neg_b_reg;
            base_c_reg <= base_b_reg;
            prod_c_reg <= PW'(mag_b_reg) * PW'(frac_b_reg);
        end
    end

    assign prod_neg  = neg_c_reg;
    assign prod_base = base_c_reg;
    assign prod_mag  = prod_c_reg;

endmodule

// ----- hw/rtl/srlr_merge.sv -----
// ----------------------------------------------------------------------------
// Resampler output merge
// Finishes both lanes' blends and registers the combined output frame word.
// ----------------------------------------------------------------------------
module srlr_merge #(
    parameter int FRAC_BITS = srlr_pkg::FRAC_BITS_DEF
) (
    input  logic                                         clk,
    input  logic                                         en_out,
    input  logic                                         left_neg,
    input  logic signed [srlr_pkg::DATA_W-1:0]           left_base,
    input  logic        [srlr_pkg::DATA_W+FRAC_BITS-1:0] left_mag,
    input  logic                                         right_neg,
    input  logic signed [srlr_pkg::DATA_W-1:0]           right_base,
    input  logic        [srlr_pkg::DATA_W+FRAC_BITS-1:0] right_mag,
    input  logic        [srlr_pkg::BUF_W-1:0]            buffered,
    output logic signed [srlr_pkg::DATA_W-1:0]           out_left,
    output logic signed [srlr_pkg::DATA_W-1:0]           out_right,
    output logic        [srlr_pkg::BUF_W-1:0]            frames_buffered
);

    localparam int DW = srlr_pkg::DATA_W;
    localparam int PW = DW + FRAC_BITS;

    logic signed [DW-1:0]  left_reg;
    logic signed [DW-1:0]  right_reg;
    logic [srlr_pkg::BUF_W-1:0] buffered_reg;

    // Drop the fraction bits of the scaled magnitude, then apply the sign.
    // The quotient is truncated toward zero because the magnitude is used.
    function automatic logic [DW-1:0] finish(input logic neg,
                                             input logic signed [DW-1:0] base,
                                             input logic [PW-1:0] mag);
        logic [DW+1:0] q;
        logic [DW+1:0] sum;
        q   = {2'b00, mag[PW-1:FRAC_BITS]};
        sum = neg ? ({{2{base[DW-1]}}, base} - q) : ({{2{base[DW-1]}}, base} + q);
        return sum[DW-1:0];
    endfunction

    // Output frame register.
    always_ff @(posedge clk)
    begin
        if (en_out)
        begin
            left_reg     <= finish(left_neg, left_base, left_mag);
            right_reg    <= finish(right_neg, right_base, right_mag);
            buffered_reg <= buffered;
        end
    end

    assign out_left        = left_reg;
    assign out_right       = right_reg;
    assign frames_buffered = buffered_reg;

endmodule

// ----- hw/rtl/stereo_ring_linear_resampler_top.sv -----
// ----------------------------------------------------------------------------
// Stereo ring linear resampler
// Push words fill a stereo frame ring; each pull word yields one frame blended
// between two neighboring ring frames by the phase fraction.
// ----------------------------------------------------------------------------
// Pipeline: a pull word passes stages A, B, C and the output frame register.
// Throughput: one word per cycle, push or pull, unless the output stalls; the
// ring RAM's two read ports serve both frames of a blend in the same cycle.
// Reset: indexes, phase, pipeline valids and the ring fill mark clear at once;
// ring slots never written read as zero, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module stereo_ring_linear_resampler_top #(
    parameter int RING_AW   = srlr_pkg::RING_AW_DEF,
    parameter int FRAC_BITS = srlr_pkg::FRAC_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [srlr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [srlr_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    srlr_in_if.sink                           in_ch,
    srlr_out_if.source                        out_ch
);

    localparam int DW          = srlr_pkg::DATA_W;
    localparam int RING_FRAMES = 1 << RING_AW;
    localparam int IDX_W       = RING_AW + 1;
    localparam int SUM_W       = srlr_pkg::SUM_W;
    localparam int BUF_W       = srlr_pkg::BUF_W;
    localparam int PW          = DW + FRAC_BITS;

    // Configuration registers.
    logic [srlr_pkg::STEP_W-1:0] phase_step_reg;
    logic                        interp_on_reg;

    // Ring pointers and phase.
    logic [IDX_W-1:0]     write_index_reg, write_index_next;
    logic [IDX_W-1:0]     read_index_reg, read_index_next;
    logic [FRAC_BITS-1:0] phase_frac_reg, phase_frac_next;
    logic                 ring_full_reg, ring_full_next;

    // Pipeline valids.
    logic a_valid_reg, b_valid_reg, c_valid_reg, out_valid_reg;
    logic en_a, en_b, en_c, en_out;
    srlr_pkg::lane_ctrl_t lane_ctl;

    // Accept decode.
    logic accept, do_push, do_pull;

    // Phase arithmetic.
    logic [SUM_W-1:0]       phase_sum;
    logic [SUM_W-1:0]       whole_full;
    logic [IDX_W-1:0]       buffered_full;
    logic [BUF_W+IDX_W-1:0] buffered_ext;

    // Ring addressing and fill check.
    logic [RING_AW-1:0] first_slot, second_slot, write_slot;
    logic               first_known, second_known;
    logic [2*DW-1:0]    ram_first, ram_second;

    // Stage A payload.
    logic                 first_known_reg, second_known_reg;
    logic [FRAC_BITS-1:0] frac_a_reg;
    logic [BUF_W-1:0]     buf_a_reg, buf_b_reg, buf_c_reg;
    logic [2*DW-1:0]      first_word, second_word;

    // Lane results.
    logic                 left_neg, right_neg;
    logic signed [DW-1:0] left_base, right_base;
    logic [PW-1:0]        left_mag, right_mag;

    // Each stage moves when the one after it is empty or moving.
    assign en_out = !out_valid_reg || out_ch.ready;
    assign en_c   = !c_valid_reg || en_out;
    assign en_b   = !b_valid_reg || en_c;
    assign en_a   = !a_valid_reg || en_b;

    assign lane_ctl.en_b = en_b;
    assign lane_ctl.en_c = en_c;

    assign in_ch.ready = en_a;
    assign accept      = in_ch.valid && en_a;
    assign do_push     = accept && (in_ch.req_type == srlr_pkg::REQ_PUSH);
    assign do_pull     = accept && (in_ch.req_type == srlr_pkg::REQ_PULL);

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_step_reg <= srlr_pkg::PHASE_STEP_RST;
            interp_on_reg  <= srlr_pkg::INTERP_ON_RST;
        end
        else if (cfg_we)
        begin
            unique case (srlr_pkg::cfg_reg_t'(cfg_index))
                srlr_pkg::REG_PHASE_STEP: phase_step_reg <= cfg_wdata[srlr_pkg::STEP_W-1:0];
                srlr_pkg::REG_INTERP_ON:  interp_on_reg  <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Ring slots and whether they have been written since reset.
    assign write_slot   = write_index_reg[RING_AW-1:0];
    assign first_slot   = read_index_reg[RING_AW-1:0];
    assign second_slot  = first_slot + 1'b1;
    assign first_known  = ring_full_reg || (first_slot < write_slot);
    assign second_known = ring_full_reg || (second_slot < write_slot);

    // Phase advance: whole frames go to the read index, the fraction stays.
    assign phase_sum  = {{(SUM_W-FRAC_BITS){1'b0}}, phase_frac_reg}
                      + {{(SUM_W-srlr_pkg::STEP_W){1'b0}}, phase_step_reg};
    assign whole_full = phase_sum >> FRAC_BITS;

    // Pointer next state.
    always_comb
    begin
        write_index_next = write_index_reg;
        read_index_next  = read_index_reg;
        phase_frac_next  = phase_frac_reg;
        ring_full_next   = ring_full_reg;
        if (do_push)
        begin
            write_index_next = write_index_reg + 1'b1;
            if (write_slot == {RING_AW{1'b1}})
            begin
                ring_full_next = 1'b1;
            end
        end
        if (do_pull)
        begin
            read_index_next = read_index_reg + whole_full[IDX_W-1:0];
            phase_frac_next = phase_sum[FRAC_BITS-1:0];
        end
    end

    // Fill level after the pull, cut to the output field width.
    assign buffered_full = write_index_reg - read_index_next;
    assign buffered_ext  = {{BUF_W{1'b0}}, buffered_full};

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            write_index_reg <= '0;
            read_index_reg  <= '0;
            phase_frac_reg  <= '0;
            ring_full_reg   <= 1'b0;
            a_valid_reg     <= 1'b0;
            b_valid_reg     <= 1'b0;
            c_valid_reg     <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            write_index_reg <= write_index_next;
            read_index_reg  <= read_index_next;
            phase_frac_reg  <= phase_frac_next;
            ring_full_reg   <= ring_full_next;
            if (en_a)
            begin
                a_valid_reg <= do_pull;
            end
            if (en_b)
            begin
                b_valid_reg <= a_valid_reg;
            end
            if (en_c)
            begin
                c_valid_reg <= b_valid_reg;
            end
            if (en_out)
            begin
                out_valid_reg <= c_valid_reg;
            end
        end
    end

    // Frame ring: left sample in the upper half of each word.
    srlr_ram #(
        .WIDTH (2 * DW),
        .DEPTH (RING_FRAMES)
    ) u_ring (
        .clk     (clk),
        .we      (do_push),
        .waddr   (write_slot),
        .wdata   ({in_ch.in_left, in_ch.in_right}),
        .re      (en_a),
        .raddr_a (first_slot),
        .raddr_b (second_slot),
        .rdata_a (ram_first),
        .rdata_b (ram_second)
    );

    // Stage A payload, loaded together with the ring read data.
    // Nearest mode blends with a zero fraction, which leaves the first frame.
    always_ff @(posedge clk)
    begin
        if (en_a)
        begin
            first_known_reg  <= first_known;
            second_known_reg <= second_known;
            frac_a_reg       <= interp_on_reg ? phase_frac_reg : '0;
            buf_a_reg        <= buffered_ext[BUF_W-1:0];
        end
    end

    // Fill level travels alongside the lanes.
    always_ff @(posedge clk)
    begin
        if (en_b)
        begin
            buf_b_reg <= buf_a_reg;
        end
        if (en_c)
        begin
            buf_c_reg <= buf_b_reg;
        end
    end

    // Slots never written since reset read as zero.
    assign first_word  = first_known_reg  ? ram_first  : '0;
    assign second_word = second_known_reg ? ram_second : '0;

    // Left channel lane.
    srlr_lane #(
        .FRAC_BITS (FRAC_BITS)
    ) u_lane_left (
        .clk       (clk),
        .ctl       (lane_ctl),
        .first     (first_word[2*DW-1:DW]),
        .second    (second_word[2*DW-1:DW]),
        .frac      (frac_a_reg),
        .prod_neg  (left_neg),
        .prod_base (left_base),
        .prod_mag  (left_mag)
    );

    // Right channel lane.
    srlr_lane #(
        .FRAC_BITS (FRAC_BITS)
    ) u_lane_right (
        .clk       (clk),
        .ctl       (lane_ctl),
        .first     (first_word[DW-1:0]),
        .second    (second_word[DW-1:0]),
        .frac      (frac_a_reg),
        .prod_neg  (right_neg),
        .prod_base (right_base),
        .prod_mag  (right_mag)
    );

    // Merge both lanes into the output frame word.
    srlr_merge #(
        .FRAC_BITS (FRAC_BITS)
    ) u_merge (
        .clk             (clk),
        .en_out          (en_out),
        .left_neg        (left_neg),
        .left_base       (left_base),
        .left_mag        (left_mag),
        .right_neg       (right_neg),
        .right_base      (right_base),
        .right_mag       (right_mag),
        .buffered        (buf_c_reg),
        .out_left        (out_ch.out_left),
        .out_right       (out_ch.out_right),
        .frames_buffered (out_ch.frames_buffered)
    );

    assign out_ch.valid = out_valid_reg;

endmodule
